@@ rtl/core/rse_pkg.sv @@
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types, constants and arithmetic helpers for the RGB Sobel edge unit.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 12;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int PIX_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [CFG_W-1:0] DIM_MIN      = 12'd3;
    localparam logic [CFG_W:0]   WIDTH_MAX    = (CFG_W+1)'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] HEIGHT_MAX   = 12'd4095;

    // BT.709 luma weights, Q16 (sum is exactly 65536)
    localparam logic [15:0] LUMA_R = 16'd13933;
    localparam logic [15:0] LUMA_G = 16'd46871;
    localparam logic [15:0] LUMA_B = 16'd4732;

    localparam logic [PIX_W-1:0] MAG_SAT = 8'd255;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]       edge_res;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             frame_last;
    } t_res_out;

    // one window column: top, middle, bottom gray
    typedef logic [3*PIX_W-1:0] t_win_col;

    function automatic logic [PIX_W-1:0] to_gray(input logic [7:0] r,
                                                 input logic [7:0] g,
                                                 input logic [7:0] b);
        logic [23:0] acc;
        acc = 24'(LUMA_R) * 24'(r) + 24'(LUMA_G) * 24'(g) + 24'(LUMA_B) * 24'(b);
        return acc[23:16];
    endfunction

    function automatic logic [CFG_W-1:0] sat_width(input logic [CFG_W-1:0] w);
        logic [CFG_W-1:0] v;
        v = w;
        if (w < DIM_MIN) v = DIM_MIN;
        if ({1'b0, w} > WIDTH_MAX) v = WIDTH_MAX[CFG_W-1:0];
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] sat_height(input logic [CFG_W-1:0] h);
        logic [CFG_W-1:0] v;
        v = h;
        if (h < DIM_MIN) v = DIM_MIN;
        if (h > HEIGHT_MAX) v = HEIGHT_MAX;
        return v;
    endfunction

    // |Gx|+|Gy| over a 3x3 window, c0 = leftmost column
    function automatic logic [PIX_W-1:0] sobel_mag(input t_win_col c0,
                                                   input t_win_col c1,
                                                   input t_win_col c2);
        logic signed [11:0] gx;
        logic signed [11:0] gy;
        logic        [11:0] ax;
        logic        [11:0] ay;
        logic        [12:0] mag;
        gx = 12'(c0[23:16]) + 12'({c0[15:8], 1'b0}) + 12'(c0[7:0])
           - 12'(c2[23:16]) - 12'({c2[15:8], 1'b0}) - 12'(c2[7:0]);
        gy = 12'(c0[23:16]) + 12'({c1[23:16], 1'b0}) + 12'(c2[23:16])
           - 12'(c0[7:0]) - 12'({c1[7:0], 1'b0}) - 12'(c2[7:0]);
        ax = gx[11] ? 12'(-gx) : 12'(gx);
        ay = gy[11] ? 12'(-gy) : 12'(gy);
        mag = 13'(ax) + 13'(ay);
        return (mag > 13'(MAG_SAT)) ? MAG_SAT : mag[PIX_W-1:0];
    endfunction

endpackage

@@ rtl/core/rgb_sobel_edge_stream_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_sobel_edge_stream_unit
// Streaming 3x3 Sobel edge detector on raster-order RGB pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel (i_pix_valid / o_pix_stall / i_pix): one RGB item per
//   accepted edge, raster order. frame_start forces the item to (0,0);
//   otherwise position wraps on the configured width and height.
//   Result channel (o_res_valid / i_res_stall / o_res): one item for each
//   interior pixel (r-1,c-1), produced when pixel (r,c) with r,c >= 2
//   arrives. Border pixels produce nothing.
//   Config channel (i_cfg_valid / o_cfg_ready): index 0 frame_width,
//   index 1 frame_height; always ready. Write only while the pipe is empty.
//   Throughput: one item per clock while not stalled. Each result passes
//   stage 1, stage 2 and output register. The rate is set by the single
//   line-buffer RAM, read and written once per item in a 2-stage RMW.
//   Stalls: a held result under i_res_stall freezes the whole pipe;
//   o_pix_stall rises only while a finished result is held and stalled.
//   Reset: counters, window and valid bits clear; width 640, height 480.
//   Line buffer contents are not cleared.
// ----------------------------------------------------------------------------
module rgb_sobel_edge_stream_unit
    import rse_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pix_valid,
    output logic                 o_pix_stall,
    input  t_pix_in              i_pix,
    output logic                 o_res_valid,
    input  logic                 i_res_stall,
    output t_res_out             o_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // config registers
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    // position counters
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    // line buffer: {upper, middle} per column
    logic [2*PIX_W-1:0] mem [0:MAX_WIDTH-1];
    logic [2*PIX_W-1:0] r_rd;

    // stage 1: item with pending RMW
    logic             r_s1_valid;
    logic [COL_W-1:0] r_s1_col;
    logic [PIX_W-1:0] r_s1_gray;
    logic             r_s1_emit;
    logic [ROW_W-1:0] r_s1_orow;
    logic [COL_W-1:0] r_s1_ocol;
    logic             r_s1_last;

    // stage 2: window
    t_win_col         r_win0;
    t_win_col         r_win1;
    t_win_col         r_win2;
    logic             r_s2_valid;
    logic [ROW_W-1:0] r_s2_orow;
    logic [COL_W-1:0] r_s2_ocol;
    logic             r_s2_last;

    // output register
    logic             r_out_valid;
    t_res_out         r_out;

    logic             en;
    logic             acc;
    logic [COL_W-1:0] c_in;
    logic [ROW_W-1:0] r_in;
    logic [CFG_W-1:0] w_used;
    logic [CFG_W-1:0] h_used;
    logic [CFG_W-1:0] c_plus1;
    logic [ROW_W:0]   r_plus1;
    logic             col_end;
    logic             row_end;
    logic [PIX_W-1:0] gray_in;
    logic             fwd;

    // whole pipe advances unless a held result is stalled
    assign en          = !r_out_valid || !i_res_stall;
    assign acc         = i_pix_valid && en;
    assign o_pix_stall = !en;
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_used  = sat_width(r_width);
    assign h_used  = sat_height(r_height);
    assign c_in    = i_pix.frame_start ? '0 : r_col;
    assign r_in    = i_pix.frame_start ? '0 : r_row;
    assign c_plus1 = CFG_W'(c_in) + CFG_W'(1);
    assign r_plus1 = (ROW_W+1)'(r_in) + (ROW_W+1)'(1);
    assign col_end = c_plus1 >= w_used;
    assign row_end = r_plus1 >= (ROW_W+1)'(h_used);
    assign gray_in = to_gray(i_pix.red, i_pix.green, i_pix.blue);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : r_plus1[ROW_W-1:0];
        end else begin
            n_col = c_plus1[COL_W-1:0];
            n_row = r_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // RMW: stage 1 writes back the same edge the next item reads;
    // same column back to back (frame_start at col 0) is forwarded.
    assign fwd = r_s1_valid && (r_s1_col == c_in);

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_s1_valid) begin
                mem[r_s1_col] <= {r_rd[PIX_W-1:0], r_s1_gray};
            end
            if (acc) begin
                r_rd <= fwd ? {r_rd[PIX_W-1:0], r_s1_gray} : mem[c_in];
            end
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_col  <= c_in;
            r_s1_gray <= gray_in;
            r_s1_emit <= (r_in >= ROW_W'(2)) && (c_in >= COL_W'(2));
            r_s1_orow <= r_in - ROW_W'(1);
            r_s1_ocol <= c_in - COL_W'(1);
            r_s1_last <= (r_plus1 == (ROW_W+1)'(h_used)) && (c_plus1 == w_used);
        end
    end

    // stage 2: shift window on real items only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_win0     <= '0;
            r_win1     <= '0;
            r_win2     <= '0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
            if (r_s1_valid) begin
                r_win0 <= r_win1;
                r_win1 <= r_win2;
                r_win2 <= {r_rd, r_s1_gray};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s1_valid) begin
            r_s2_orow <= r_s1_orow;
            r_s2_ocol <= r_s1_ocol;
            r_s2_last <= r_s1_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s2_valid) begin
            r_out.edge_res   <= sobel_mag(r_win0, r_win1, r_win2);
            r_out.out_row    <= r_s2_orow;
            r_out.out_col    <= r_s2_ocol;
            r_out.frame_last <= r_s2_last;
        end
    end

endmodule

@@ rtl/core/rse_checker.sv @@
// ----------------------------------------------------------------------------
// rse_checker
// Port-level checks for the RGB Sobel edge unit, bound to the top level.
// ----------------------------------------------------------------------------
module rse_checker
    import rse_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_pix_stall,
    input logic     o_res_valid,
    input logic     i_res_stall,
    input t_res_out o_res
);

    // held result keeps still
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_res))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    assert property (@(posedge i_clk) !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    // results never lie on the top row or left column
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.out_row != '0) && (o_res.out_col != '0))
        else $error("border pixel reported");

    // input is held off only by a stalled result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix_stall |-> o_res_valid && i_res_stall)
        else $error("input stalled without output backpressure");

endmodule

bind rgb_sobel_edge_stream_unit rse_checker u_rse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_pix_stall (o_pix_stall),
    .o_res_valid (o_res_valid),
    .i_res_stall (i_res_stall),
    .o_res       (o_res)
);
